### hdl/psca_pkg.sv
`default_nettype none

package psca_pkg;

  localparam int unsigned ACC_W = 32;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  // first odd trial divisor, and its square
  localparam int unsigned FIRST_ODD_DIV = 3;
  localparam int unsigned FIRST_ODD_SQ = FIRST_ODD_DIV * FIRST_ODD_DIV;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic next_div;
    logic finish;
    logic prime;
  } cmd_t;

  typedef struct packed {
    logic trivial;
    logic trivial_prime;
    logic sq_over;
    logic div_last;
    logic rem_zero;
  } status_t;

endpackage

`default_nettype wire

### hdl/psca_if.sv
`default_nettype none

interface psca_in_if #(
  parameter int unsigned VALUE_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic                   last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink (input valid, input value, input last_item, output ready);
endinterface

interface psca_out_if;
  logic        valid;
  logic        ready;
  logic        is_prime;
  logic [31:0] prime_sum;
  logic [31:0] prime_count;
  logic        end_of_array;

  modport source (
    output valid, output is_prime, output prime_sum, output prime_count,
    output end_of_array, input ready
  );
  modport sink (
    input valid, input is_prime, input prime_sum, input prime_count,
    input end_of_array, output ready
  );
endinterface

`default_nettype wire

### hdl/psca_ctrl.sv
`default_nettype none

module psca_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  input  wire psca_pkg::status_t status_i,
  output psca_pkg::cmd_t         cmd_o
);
  import psca_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TEST,
    S_DIV,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   prime_q, prime_d;

  always_comb begin
    state_d     = state_q;
    prime_d     = prime_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_TEST;
        end
      end
      S_TEST: begin
        if (status_i.trivial) begin
          prime_d = status_i.trivial_prime;
          state_d = S_DONE;
        end else if (status_i.sq_over) begin
          prime_d = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          if (status_i.rem_zero) begin
            prime_d = 1'b0;
            state_d = S_DONE;
          end else begin
            cmd_o.next_div = 1'b1;
            state_d        = S_TEST;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          cmd_o.prime  = prime_q;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      prime_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      prime_q     <= prime_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### hdl/psca_dpath.sv
`default_nettype none

module psca_dpath #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire psca_pkg::cmd_t         cmd_i,
  output psca_pkg::status_t           status_o,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  input  wire logic                   last_item_i,
  output logic                        is_prime_o,
  output logic [31:0]                 prime_sum_o,
  output logic [31:0]                 prime_count_o,
  output logic                        end_of_array_o
);
  import psca_pkg::*;

  localparam int unsigned VW  = VALUE_WIDTH;
  localparam int unsigned DW  = (VW + 1) / 2 + 2;
  localparam int unsigned SQW = 2 * DW;
  localparam int unsigned CW  = $clog2(VW);

  logic [VW-1:0]  n_q;
  logic           last_q;
  logic [DW-1:0]  div_q;
  logic [SQW-1:0] sq_q;
  logic [DW-1:0]  rem_q, rem_d;
  logic [CW-1:0]  cnt_q;
  logic [ACC_W-1:0] sum_q, count_q;

  logic [DW:0]      shifted;
  logic [DW:0]      diff;
  logic             ge;
  logic [ACC_W:0]   sum_ext;
  logic [ACC_W-1:0] sum_new, count_new;

  // one bit of restoring remainder per cycle, msb first
  assign shifted = {rem_q, n_q[cnt_q]};
  assign diff    = shifted - {1'b0, div_q};
  assign ge      = shifted >= {1'b0, div_q};
  assign rem_d   = ge ? diff[DW-1:0] : shifted[DW-1:0];

  assign status_o.trivial       = ((n_q >> 2) == '0) || !n_q[0];
  assign status_o.trivial_prime = (n_q >> 1) == VW'(1);
  assign status_o.sq_over       = sq_q > SQW'(n_q);
  assign status_o.div_last      = cnt_q == '0;
  assign status_o.rem_zero      = rem_d == '0;

  // saturating accumulate
  assign sum_ext = {1'b0, sum_q} + (ACC_W + 1)'(n_q);
  always_comb begin
    sum_new   = sum_q;
    count_new = count_q;
    if (cmd_i.prime) begin
      sum_new   = sum_ext[ACC_W] ? ACC_MAX : sum_ext[ACC_W-1:0];
      count_new = (count_q == ACC_MAX) ? ACC_MAX : count_q + ACC_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q    <= value_i;
      last_q <= last_item_i;
      div_q  <= DW'(FIRST_ODD_DIV);
      sq_q   <= SQW'(FIRST_ODD_SQ);
    end else if (cmd_i.next_div) begin
      // (d+2)^2 = d^2 + 4d + 4
      div_q <= div_q + DW'(2);
      sq_q  <= sq_q + (SQW'(div_q) << 2) + SQW'(4);
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      cnt_q <= CW'(VW - 1);
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      cnt_q <= cnt_q - CW'(1);
    end
    if (cmd_i.finish) begin
      is_prime_o     <= cmd_i.prime;
      prime_sum_o    <= sum_new;
      prime_count_o  <= count_new;
      end_of_array_o <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (cmd_i.finish) begin
      if (last_q) begin
        sum_q   <= '0;
        count_q <= '0;
      end else begin
        sum_q   <= sum_new;
        count_q <= count_new;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/prime_sum_count_accumulator.sv
`default_nettype none

// Prime sum and count accumulator. Each input transfer carries an unsigned value and
// a last-of-array mark; for each one the block returns one output transfer with the
// primality of the value, the running sum and count of primes in the current array
// (this value included, both saturating at 2^32-1) and a copy of the mark, after
// which a marked item clears the totals. One item is in work at a time; the output
// register lets the next item start while a result waits. Values below 4 and even
// values go from S_TEST straight to S_DONE with no trial division. Odd values are
// tested against odd divisors 3, 5, 7, ... while the divisor squared is at most the
// value, each by a one-bit-per-cycle restoring remainder unit; a 16-bit prime near
// the top of the range tries about 128 divisors.
module prime_sum_count_accumulator #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  psca_in_if.sink    in_i,
  psca_out_if.source out_o
);
  import psca_pkg::*;

  cmd_t    cmd;
  status_t status;

  psca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  psca_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .value_i        (in_i.value),
    .last_item_i    (in_i.last_item),
    .is_prime_o     (out_o.is_prime),
    .prime_sum_o    (out_o.prime_sum),
    .prime_count_o  (out_o.prime_count),
    .end_of_array_o (out_o.end_of_array)
  );

endmodule

`default_nettype wire
